// ===== sv/ordered_array_list_engine_assert.svh =====
// assertion macros shared by the ordered list engine modules
`ifndef ORDERED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst is high
`define OLAE_AST_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst is high
`define OLAE_AST_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/olae_pkg.sv =====
// shared codes and controller/datapath interface types for the ordered list engine
`default_nettype none
package olae_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 3;
  localparam int IDX_W    = 6;
  localparam int COUNT_W  = 7;

  // command codes
  localparam logic [CMD_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [CMD_W-1:0] OP_PREPEND   = 3'd1;
  localparam logic [CMD_W-1:0] OP_REM_LAST  = 3'd2;
  localparam logic [CMD_W-1:0] OP_REM_FIRST = 3'd3;
  localparam logic [CMD_W-1:0] OP_INS_BEFORE = 3'd4;
  localparam logic [CMD_W-1:0] OP_INS_AFTER = 3'd5;
  localparam logic [CMD_W-1:0] OP_DELETE    = 3'd6;
  localparam logic [CMD_W-1:0] OP_FIND      = 3'd7;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic              latch;     // capture the input beat
    logic              init_up;   // pointer to count, for a shift toward the tail
    logic              init_dn;   // pointer to one past the gap, for a shift toward the head
    logic              init_scan; // pointer to zero, for a search
    logic              rd;        // read the memory, step the pointer
    logic              rd_dec;    // read below the pointer and step down
    logic              mv_wr;     // write back the entry read last cycle
    logic              mv_up;     // write it one slot higher, else one lower
    logic              put;       // write the new value at the insert slot
    logic              cnt_inc;
    logic              cnt_dec;
    logic              set_st;
    logic [STAT_W-1:0] st_code;
    logic              set_found; // record the index of the entry just compared
    logic              load_out;  // move the result into the output register
  } olae_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             full;
    logic             empty;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             ptr_gt_at;
    logic             ptr_lt_cnt;
    logic             match;
  } olae_stat_t;

endpackage
`default_nettype wire

// ===== sv/olae_ctrl.sv =====
// controller state machine of the ordered list engine
`default_nettype none
module olae_ctrl
  import olae_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire olae_stat_t st,
  output olae_ctl_t       ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SHUP   = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_SHDN   = 3'd4;
  localparam logic [2:0] S_FIND   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_FIN;
        unique case (st.op)
          OP_APPEND, OP_PREPEND: begin
            if (st.full) begin
              ctl.set_st  = 1'b1;
              ctl.st_code = ST_FULL;
            end else begin
              ctl.init_up = 1'b1;
              state_next  = S_SHUP;
            end
          end
          OP_INS_BEFORE: begin
            priority if (st.full) begin
              ctl.set_st  = 1'b1;
              ctl.st_code = ST_FULL;
            end else if (st.pos_gt_cnt) begin
              ctl.set_st  = 1'b1;
              ctl.st_code = ST_BADPOS;
            end else begin
              ctl.init_up = 1'b1;
              state_next  = S_SHUP;
            end
          end
          OP_INS_AFTER: begin
            priority if (st.full) begin
              ctl.set_st  = 1'b1;
              ctl.st_code = ST_FULL;
            end else if (st.pos_ge_cnt) begin
              ctl.set_st  = 1'b1;
              ctl.st_code = ST_BADPOS;
            end else begin
              ctl.init_up = 1'b1;
              state_next  = S_SHUP;
            end
          end
          OP_REM_LAST: begin
            if (st.empty) begin
              ctl.set_st  = 1'b1;
              ctl.st_code = ST_EMPTY;
            end else begin
              ctl.cnt_dec = 1'b1;
            end
          end
          OP_REM_FIRST: begin
            if (st.empty) begin
              ctl.set_st  = 1'b1;
              ctl.st_code = ST_EMPTY;
            end else begin
              ctl.init_dn = 1'b1;
              state_next  = S_SHDN;
            end
          end
          OP_DELETE: begin
            priority if (st.empty) begin
              ctl.set_st  = 1'b1;
              ctl.st_code = ST_EMPTY;
            end else if (st.pos_ge_cnt) begin
              ctl.set_st  = 1'b1;
              ctl.st_code = ST_BADPOS;
            end else begin
              ctl.init_dn = 1'b1;
              state_next  = S_SHDN;
            end
          end
          OP_FIND: begin
            ctl.init_scan = 1'b1;
            state_next    = S_FIND;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      // move entries one slot up, tail first, until the gap reaches the insert slot
      S_SHUP: begin
        ctl.mv_wr = 1'b1;
        ctl.mv_up = 1'b1;
        if (st.ptr_gt_at) begin
          ctl.rd     = 1'b1;
          ctl.rd_dec = 1'b1;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        ctl.put     = 1'b1;
        ctl.cnt_inc = 1'b1;
        state_next  = S_FIN;
      end
      // move entries one slot down, from the gap toward the tail
      S_SHDN: begin
        ctl.mv_wr = 1'b1;
        if (st.ptr_lt_cnt) begin
          ctl.rd = 1'b1;
        end else begin
          ctl.cnt_dec = 1'b1;
          state_next  = S_FIN;
        end
      end
      // compare the entry read last cycle while reading the next one
      S_FIND: begin
        priority if (st.match) begin
          ctl.set_found = 1'b1;
          state_next    = S_FIN;
        end else if (st.ptr_lt_cnt) begin
          ctl.rd = 1'b1;
        end else begin
          ctl.set_st  = 1'b1;
          ctl.st_code = ST_NOTFOUND;
          state_next  = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output beat flag
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (ctl.load_out) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `include "ordered_array_list_engine_assert.svh"

  `OLAE_AST_IMP(a_out_from_fin, $rose(out_valid), $past(state) == S_FIN, "result without finish")
  `OLAE_AST_NXT(a_accept_decides, in_valid && in_ready, state == S_DECIDE, "accept not decoded")
  `OLAE_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

endmodule
`default_nettype wire

// ===== sv/olae_dp.sv =====
// datapath of the ordered list engine: entry memory, count, pointer and result registers
`default_nettype none
module olae_dp
  import olae_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [POS_W-1:0]   in_pos,
  input  wire logic [VAL_W-1:0]   in_value,
  input  wire olae_ctl_t          ctl,
  output olae_stat_t              st,
  output logic [STAT_W-1:0]       out_status,
  output logic [IDX_W-1:0]        out_index,
  output logic [COUNT_W-1:0]      out_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [VAL_W-1:0]  mem [DEPTH];

  logic [CMD_W-1:0]  op;
  logic [POS_W-1:0]  op_pos;
  logic [VAL_W-1:0]  op_value;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     ptr;
  logic              pend;
  logic [AW-1:0]     pend_idx;
  logic [VAL_W-1:0]  rd_data;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_idx;

  logic [PW-1:0]     pos_w;
  logic [PW-1:0]     cnt_w;
  logic [PW-1:0]     at_w;
  logic [PW-1:0]     pidx_w;
  logic [CW-1:0]     at_c;
  logic [CW-1:0]     rd_ptr;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic              we;

  assign pos_w  = PW'(op_pos);
  assign cnt_w  = PW'(cnt);
  assign pidx_w = PW'(pend_idx);

  // slot where the new entry lands or the removed one sits
  always_comb begin
    unique case (op)
      OP_APPEND:                at_w = cnt_w;
      OP_PREPEND, OP_REM_FIRST: at_w = '0;
      OP_INS_AFTER:             at_w = pos_w + PW'(1);
      default:                  at_w = pos_w;
    endcase
  end
  assign at_c = at_w[CW-1:0];

  // read and write addresses
  assign rd_ptr  = ctl.rd_dec ? (ptr - CW'(1)) : ptr;
  assign rd_addr = rd_ptr[AW-1:0];
  always_comb begin
    if (ctl.put) begin
      wr_addr = at_c[AW-1:0];
      wr_data = op_value;
    end else begin
      wr_addr = ctl.mv_up ? (pend_idx + AW'(1)) : (pend_idx - AW'(1));
      wr_data = rd_data;
    end
  end
  assign we = ctl.put || (ctl.mv_wr && pend);

  // entry memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // captured input beat
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op       <= in_cmd;
      op_pos   <= in_pos;
      op_value <= in_value;
    end
    if (ctl.rd) begin
      pend_idx <= rd_addr;
    end
  end

  // count, pointer and read-pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      ptr  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= ctl.rd;
      if (ctl.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (ctl.cnt_dec) begin
        cnt <= cnt - CW'(1);
      end
      priority if (ctl.init_up) begin
        ptr <= cnt;
      end else if (ctl.init_dn) begin
        ptr <= at_c + CW'(1);
      end else if (ctl.init_scan) begin
        ptr <= '0;
      end else if (ctl.rd) begin
        ptr <= ctl.rd_dec ? (ptr - CW'(1)) : (ptr + CW'(1));
      end
    end
  end

  // result of the command at work and the output register
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      res_status <= ST_OK;
      res_idx    <= '0;
    end else begin
      if (ctl.set_st) begin
        res_status <= ctl.st_code;
      end
      if (ctl.set_found) begin
        res_idx <= pidx_w[IDX_W-1:0];
      end
    end
    if (ctl.load_out) begin
      out_status <= res_status;
      out_index  <= res_idx;
      out_count  <= cnt_w[COUNT_W-1:0];
    end
  end

  // status toward the controller
  assign st.op         = op;
  assign st.full       = (cnt == CW'(DEPTH));
  assign st.empty      = (cnt == '0);
  assign st.pos_gt_cnt = (pos_w > cnt_w);
  assign st.pos_ge_cnt = (pos_w >= cnt_w);
  assign st.ptr_gt_at  = (ptr > at_c);
  assign st.ptr_lt_cnt = (ptr < cnt);
  assign st.match      = pend && (rd_data == op_value);

  `include "ordered_array_list_engine_assert.svh"

  `OLAE_AST_IMP(a_no_put_full, ctl.put, cnt != CW'(DEPTH), "insert into a full list")
  `OLAE_AST_IMP(a_no_dec_empty, ctl.cnt_dec, cnt != '0, "remove from an empty list")
  `OLAE_AST_IMP(a_put_no_move, ctl.put, !pend, "insert write collides with a move")

endmodule
`default_nettype wire

// ===== sv/ordered_array_list_engine.sv =====
// Ordered list engine: holds up to DEPTH signed 32-bit entries in a single
// memory with one write port and one registered read port, plus an entry count.
// One command is worked at a time; shifts and searches move through the memory
// one entry per cycle, reading one slot while writing back the slot read the
// cycle before. An append, prepend or insert moves the entries from its slot
// up by one, tail first, then writes the new entry; delete and remove first
// move the entries above the slot down by one; remove last only lowers the
// count; a find reads from slot 0 up to the first hit or the count. The
// memory needs no clearing after reset: only slots below the count are read.
// A finished result sits in an output register; the next command is accepted
// the cycle after that register is loaded, while its result still waits. A
// command whose result is ready waits in its last cycle as long as the
// previous result has not been taken.
`default_nettype none
module ordered_array_list_engine
  import olae_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [POS_W-1:0]    pos,
  input  wire logic signed [VAL_W-1:0] value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STAT_W-1:0]        status,
  output logic [IDX_W-1:0]         index,
  output logic [COUNT_W-1:0]       count
);

  olae_ctl_t  ctl;
  olae_stat_t st;

  // sequencing of each command
  olae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .ctl       (ctl)
  );

  // storage and compare logic
  olae_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (cmd),
    .in_pos     (pos),
    .in_value   (VAL_W'(unsigned'(value))),
    .ctl        (ctl),
    .st         (st),
    .out_status (status),
    .out_index  (index),
    .out_count  (count)
  );

endmodule
`default_nettype wire
